FILE: rtl/core/apv_pkg.sv
`timescale 1ns / 1ps

package apv_pkg;

   // default coordinate width: signed Q14.16 in 31 bits
   localparam int COORD_BITS_DEFAULT = 31;

   // push vector components are always 32-bit signed
   localparam int PUSH_BITS = 32;

   // largest push magnitude, symmetric around zero
   localparam longint PUSH_MAX = 64'sd2147483647;

   // axis codes on min_axis
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

FILE: rtl/core/apv_axis.sv
`timescale 1ns / 1ps

module apv_axis
   import apv_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic signed [COORD_BITS-1:0] own_min,
   input  logic signed [COORD_BITS-1:0] own_max,
   input  logic signed [COORD_BITS-1:0] other_min,
   input  logic signed [COORD_BITS-1:0] other_max,
   output logic signed [COORD_BITS:0]   len,
   output logic                         below
);

   logic signed [COORD_BITS-1:0] upper;
   logic signed [COORD_BITS-1:0] lower;
   logic signed [COORD_BITS:0]   own_sum;
   logic signed [COORD_BITS:0]   other_sum;

   // the four nesting cases reduce to min of the maxima minus max of the minima
   always_comb begin
      upper = (other_max > own_max) ? own_max : other_max;
      lower = (other_min < own_min) ? own_min : other_min;
      len   = (COORD_BITS+1)'(upper) - (COORD_BITS+1)'(lower);
   end

   // center compare on doubled centers, no halving needed
   always_comb begin
      own_sum   = (COORD_BITS+1)'(own_min) + (COORD_BITS+1)'(own_max);
      other_sum = (COORD_BITS+1)'(other_min) + (COORD_BITS+1)'(other_max);
      below     = other_sum < own_sum;
   end

endmodule

FILE: rtl/core/apv_select.sv
`timescale 1ns / 1ps

module apv_select
   import apv_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic signed [COORD_BITS:0]  len_x,
   input  logic signed [COORD_BITS:0]  len_y,
   input  logic signed [COORD_BITS:0]  len_z,
   input  logic                        below_x,
   input  logic                        below_y,
   input  logic                        below_z,
   output logic                        hit,
   output logic [1:0]                  min_axis,
   output logic signed [PUSH_BITS-1:0] push_x,
   output logic signed [PUSH_BITS-1:0] push_y,
   output logic signed [PUSH_BITS-1:0] push_z
);

   localparam int LEN_BITS = COORD_BITS + 1;
   localparam int SGN_BITS = LEN_BITS + 1;
   localparam int EXT_BITS = (SGN_BITS > PUSH_BITS + 1) ? SGN_BITS : PUSH_BITS + 1;
   localparam logic signed [EXT_BITS-1:0] SAT_HI = EXT_BITS'(PUSH_MAX);
   localparam logic signed [EXT_BITS-1:0] SAT_LO = -SAT_HI;

   logic signed [LEN_BITS-1:0] best;
   logic                       best_below;
   logic signed [SGN_BITS-1:0] signed_len;
   logic signed [EXT_BITS-1:0] wide_len;
   logic signed [PUSH_BITS-1:0] push;

   // ties keep the earlier axis
   always_comb begin
      best       = len_x;
      best_below = below_x;
      min_axis   = AXIS_X;
      if (len_y < best) begin
         best       = len_y;
         best_below = below_y;
         min_axis   = AXIS_Y;
      end
      if (len_z < best) begin
         best       = len_z;
         best_below = below_z;
         min_axis   = AXIS_Z;
      end
   end

   // sign by centre side, then clamp to symmetric 32-bit range
   always_comb begin
      signed_len = best_below ? -SGN_BITS'(best) : SGN_BITS'(best);
      wide_len   = EXT_BITS'(signed_len);
      if (wide_len > SAT_HI) begin
         push = SAT_HI[PUSH_BITS-1:0];
      end else if (wide_len < SAT_LO) begin
         push = SAT_LO[PUSH_BITS-1:0];
      end else begin
         push = wide_len[PUSH_BITS-1:0];
      end
   end

   always_comb begin
      hit    = (len_x > 0) && (len_y > 0) && (len_z > 0);
      push_x = (min_axis == AXIS_X) ? push : '0;
      push_y = (min_axis == AXIS_Y) ? push : '0;
      push_z = (min_axis == AXIS_Z) ? push : '0;
   end

endmodule

FILE: rtl/core/aabb_penetration_vector_top.sv
`timescale 1ns / 1ps

// channel   ports                      beat contents
// -------   -------------------------  -----------------------------------------
// req       req_valid / req_ready      own and other box corners, 12 coordinates
// rsp       rsp_valid / rsp_ready      hit flag, min_axis, push_x/y/z
//
// a req beat lands in the input register; the result register then loads from the
// overlap and axis-select logic between them once it is free
// one beat per cycle while rsp_ready holds; the input and result registers form a two-deep
// pipeline that advances whenever the result register is empty or being taken
// reset clears only the two valid flags; payload registers are not reset
// a stalled rsp holds the result stage and a full input stage, req_ready drops only when both are full

module aabb_penetration_vector_top
   import apv_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_own_min_x,
   input  logic signed [COORD_BITS-1:0] req_own_min_y,
   input  logic signed [COORD_BITS-1:0] req_own_min_z,
   input  logic signed [COORD_BITS-1:0] req_own_max_x,
   input  logic signed [COORD_BITS-1:0] req_own_max_y,
   input  logic signed [COORD_BITS-1:0] req_own_max_z,
   input  logic signed [COORD_BITS-1:0] req_other_min_x,
   input  logic signed [COORD_BITS-1:0] req_other_min_y,
   input  logic signed [COORD_BITS-1:0] req_other_min_z,
   input  logic signed [COORD_BITS-1:0] req_other_max_x,
   input  logic signed [COORD_BITS-1:0] req_other_max_y,
   input  logic signed [COORD_BITS-1:0] req_other_max_z,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [1:0]                   rsp_min_axis,
   output logic signed [PUSH_BITS-1:0]  rsp_push_x,
   output logic signed [PUSH_BITS-1:0]  rsp_push_y,
   output logic signed [PUSH_BITS-1:0]  rsp_push_z
);

   // handshake control
   logic in_valid_ff;
   logic in_valid_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic out_free;
   logic in_load;

   // input register, one entry per axis
   logic signed [COORD_BITS-1:0] own_min_ff   [3];
   logic signed [COORD_BITS-1:0] own_max_ff   [3];
   logic signed [COORD_BITS-1:0] other_min_ff [3];
   logic signed [COORD_BITS-1:0] other_max_ff [3];

   // per-axis overlap and center side
   logic signed [COORD_BITS:0] len   [3];
   logic                       below [3];

   // result logic
   logic                        hit_in;
   logic [1:0]                  min_axis_in;
   logic signed [PUSH_BITS-1:0] push_x_in;
   logic signed [PUSH_BITS-1:0] push_y_in;
   logic signed [PUSH_BITS-1:0] push_z_in;

   // result register
   logic                        hit_ff;
   logic [1:0]                  min_axis_ff;
   logic signed [PUSH_BITS-1:0] push_x_ff;
   logic signed [PUSH_BITS-1:0] push_y_ff;
   logic signed [PUSH_BITS-1:0] push_z_ff;

   // result stage can load when empty or its beat leaves this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   // input stage can load when empty or it moves forward this cycle
   assign req_ready = !in_valid_ff || out_free;
   assign in_load   = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture a req beat
   always_ff @(posedge clock) begin
      if (in_load) begin
         own_min_ff[0]   <= req_own_min_x;
         own_min_ff[1]   <= req_own_min_y;
         own_min_ff[2]   <= req_own_min_z;
         own_max_ff[0]   <= req_own_max_x;
         own_max_ff[1]   <= req_own_max_y;
         own_max_ff[2]   <= req_own_max_z;
         other_min_ff[0] <= req_other_min_x;
         other_min_ff[1] <= req_other_min_y;
         other_min_ff[2] <= req_other_min_z;
         other_max_ff[0] <= req_other_max_x;
         other_max_ff[1] <= req_other_max_y;
         other_max_ff[2] <= req_other_max_z;
      end
   end

   // one overlap unit per axis
   for (genvar a = 0; a < 3; a++) begin : g_axis
      apv_axis #(
         .COORD_BITS (COORD_BITS)
      ) u_axis (
         .own_min   (own_min_ff[a]),
         .own_max   (own_max_ff[a]),
         .other_min (other_min_ff[a]),
         .other_max (other_max_ff[a]),
         .len       (len[a]),
         .below     (below[a])
      );
   end

   // least-overlap axis and signed, clamped push
   apv_select #(
      .COORD_BITS (COORD_BITS)
   ) u_select (
      .len_x    (len[0]),
      .len_y    (len[1]),
      .len_z    (len[2]),
      .below_x  (below[0]),
      .below_y  (below[1]),
      .below_z  (below[2]),
      .hit      (hit_in),
      .min_axis (min_axis_in),
      .push_x   (push_x_in),
      .push_y   (push_y_in),
      .push_z   (push_z_in)
   );

   // result register loads whenever it is free; holds under stall
   always_ff @(posedge clock) begin
      if (out_free) begin
         hit_ff      <= hit_in;
         min_axis_ff <= min_axis_in;
         push_x_ff   <= push_x_in;
         push_y_ff   <= push_y_in;
         push_z_ff   <= push_z_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_min_axis = min_axis_ff;
   assign rsp_push_x   = push_x_ff;
   assign rsp_push_y   = push_y_ff;
   assign rsp_push_z   = push_z_ff;

endmodule

FILE: tb/tb_aabb_penetration_vector_top.sv
`timescale 1ns / 1ps

module tb_aabb_penetration_vector_top;
   import apv_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEFAULT;

   // one unit in Q14.16
   localparam longint ONE = 64'sd65536;
   localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
   localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;

   localparam int RANDOM_PAIRS = 1550;
   // receiver hold-off that backs the block up into its input
   localparam int RSP_HOLD_CYCLES = 80;
   // cycles without any beat on either channel before giving up
   localparam int QUIET_LIMIT = 1000;

   // index 0 is x, 1 is y, 2 is z
   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] own_min;
      logic [2:0][COORD_BITS-1:0] own_max;
      logic [2:0][COORD_BITS-1:0] other_min;
      logic [2:0][COORD_BITS-1:0] other_max;
   } box_pair_type;

   typedef struct packed {
      logic                 hit;
      logic [1:0]           min_axis;
      logic [PUSH_BITS-1:0] push_x;
      logic [PUSH_BITS-1:0] push_y;
      logic [PUSH_BITS-1:0] push_z;
   } push_beat_type;

   // holds the push vectors still owed by the block, oldest first
   class push_vector_book;
      push_beat_type expected_pushes[$];
      int unsigned   mismatches;

      function new();
         mismatches = 0;
      endfunction

      // least-overlap axis and push vector for one box pair
      function push_beat_type predict_push(box_pair_type p);
         longint        lo[3], hi[3], olo[3], ohi[3], overlap[3];
         longint        best, push;
         logic [1:0]    axis;
         push_beat_type r;
         for (int a = 0; a < 3; a++) begin
            lo[a]  = longint'($signed(p.own_min[a]));
            hi[a]  = longint'($signed(p.own_max[a]));
            olo[a] = longint'($signed(p.other_min[a]));
            ohi[a] = longint'($signed(p.other_max[a]));
            // four nesting cases: which box bounds each end of the overlap
            if (ohi[a] > hi[a]) begin
               overlap[a] = (olo[a] < lo[a]) ? hi[a] - lo[a] : hi[a] - olo[a];
            end else begin
               overlap[a] = (olo[a] < lo[a]) ? ohi[a] - lo[a] : ohi[a] - olo[a];
            end
         end
         // strict compare keeps ties on the lower axis
         best = overlap[0];
         axis = AXIS_X;
         if (overlap[1] < best) begin
            best = overlap[1];
            axis = AXIS_Y;
         end
         if (overlap[2] < best) begin
            best = overlap[2];
            axis = AXIS_Z;
         end
         // other center below own center pushes negative, equal centers positive
         if (olo[axis] + ohi[axis] < lo[axis] + hi[axis]) begin
            push = -best;
         end else begin
            push = best;
         end
         if (push > PUSH_MAX) begin
            push = PUSH_MAX;
         end
         if (push < -PUSH_MAX) begin
            push = -PUSH_MAX;
         end
         r.hit      = (overlap[0] > 0) && (overlap[1] > 0) && (overlap[2] > 0);
         r.min_axis = axis;
         r.push_x   = (axis == AXIS_X) ? push[PUSH_BITS-1:0] : '0;
         r.push_y   = (axis == AXIS_Y) ? push[PUSH_BITS-1:0] : '0;
         r.push_z   = (axis == AXIS_Z) ? push[PUSH_BITS-1:0] : '0;
         return r;
      endfunction

      function void note_pair(box_pair_type p);
         expected_pushes = {expected_pushes, predict_push(p)};
      endfunction

      function int unsigned outstanding();
         return expected_pushes.size();
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_push(push_beat_type got);
         push_beat_type want;
         if (expected_pushes.size() == 0) begin
            $display("%0t ns: rsp beat with nothing expected, got hit %0d axis %0d",
                     $time, got.hit, got.min_axis);
            $display("%0t ns: unexpected push %0d %0d %0d", $time, $signed(got.push_x),
                     $signed(got.push_y), $signed(got.push_z));
            mismatches++;
            return;
         end
         want = expected_pushes.pop_front();
         compare_field("hit", longint'(want.hit), longint'(got.hit));
         compare_field("min_axis", longint'(want.min_axis), longint'(got.min_axis));
         compare_field("push_x", longint'($signed(want.push_x)), longint'($signed(got.push_x)));
         compare_field("push_y", longint'($signed(want.push_y)), longint'($signed(got.push_y)));
         compare_field("push_z", longint'($signed(want.push_z)), longint'($signed(got.push_z)));
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [COORD_BITS-1:0] req_own_min_x = '0;
   logic signed [COORD_BITS-1:0] req_own_min_y = '0;
   logic signed [COORD_BITS-1:0] req_own_min_z = '0;
   logic signed [COORD_BITS-1:0] req_own_max_x = '0;
   logic signed [COORD_BITS-1:0] req_own_max_y = '0;
   logic signed [COORD_BITS-1:0] req_own_max_z = '0;
   logic signed [COORD_BITS-1:0] req_other_min_x = '0;
   logic signed [COORD_BITS-1:0] req_other_min_y = '0;
   logic signed [COORD_BITS-1:0] req_other_min_z = '0;
   logic signed [COORD_BITS-1:0] req_other_max_x = '0;
   logic signed [COORD_BITS-1:0] req_other_max_y = '0;
   logic signed [COORD_BITS-1:0] req_other_max_z = '0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_hit;
   logic [1:0]                  rsp_min_axis;
   logic signed [PUSH_BITS-1:0] rsp_push_x;
   logic signed [PUSH_BITS-1:0] rsp_push_y;
   logic signed [PUSH_BITS-1:0] rsp_push_z;

   // random idling on both sides; cleared for one long stretch
   bit idle_enable = 1'b1;
   // set by the stimulus, cleared by the receiver when its hold-off ends
   bit hold_rsp = 1'b0;

   push_vector_book book = new();
   box_pair_type    seen_pair;
   push_beat_type   seen_push;
   int unsigned     quiet_cycles;

   aabb_penetration_vector_top #(
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_own_min_x(req_own_min_x),
      .req_own_min_y(req_own_min_y),
      .req_own_min_z(req_own_min_z),
      .req_own_max_x(req_own_max_x),
      .req_own_max_y(req_own_max_y),
      .req_own_max_z(req_own_max_z),
      .req_other_min_x(req_other_min_x),
      .req_other_min_y(req_other_min_y),
      .req_other_min_z(req_other_min_z),
      .req_other_max_x(req_other_max_x),
      .req_other_max_y(req_other_max_y),
      .req_other_max_z(req_other_max_z),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit),
      .rsp_min_axis(rsp_min_axis),
      .rsp_push_x(rsp_push_x),
      .rsp_push_y(rsp_push_y),
      .rsp_push_z(rsp_push_z)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // coordinates arrive as longints and are cut to the port width here
   function automatic box_pair_type with_axis(box_pair_type p, int a, longint lo, longint hi,
                                              longint olo, longint ohi);
      p.own_min[a]   = lo[COORD_BITS-1:0];
      p.own_max[a]   = hi[COORD_BITS-1:0];
      p.other_min[a] = olo[COORD_BITS-1:0];
      p.other_max[a] = ohi[COORD_BITS-1:0];
      return p;
   endfunction

   function automatic box_pair_type uniform_pair(longint lo, longint hi, longint olo,
                                                 longint ohi);
      box_pair_type p;
      p = '0;
      for (int a = 0; a < 3; a++) begin
         p = with_axis(p, a, lo, hi, olo, ohi);
      end
      return p;
   endfunction

   // extremes, tiny values near zero, or any bit pattern at all
   function automatic longint noise_coord();
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(3))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return 0;
               default: return -1;
            endcase
         end
         1: return longint'($urandom_range(16)) - 8;
         default: return longint'($urandom());
      endcase
   endfunction

   // mostly boxes that sit near each other so overlaps and ties are common,
   // some with a box turned inside out, the rest pure noise
   function automatic box_pair_type random_pair();
      box_pair_type p;
      int unsigned  shape;
      longint       span, lo, hi, olo, ohi;
      p = '0;
      shape = $urandom_range(99);
      for (int a = 0; a < 3; a++) begin
         if (shape < 80) begin
            case ($urandom_range(2))
               0: span = 8;
               1: span = longint'(1) << 20;
               default: span = longint'(1) << 27;
            endcase
            lo  = longint'($urandom_range(1 << 29)) - (longint'(1) << 28);
            hi  = lo + longint'($urandom_range(span));
            olo = lo - span + longint'($urandom_range(2 * span));
            ohi = olo + longint'($urandom_range(span));
            if (shape >= 70 && $urandom_range(1) == 0) begin
               p = with_axis(p, a, hi, lo, olo, ohi);
            end else if (shape >= 70) begin
               p = with_axis(p, a, lo, hi, ohi, olo);
            end else begin
               p = with_axis(p, a, lo, hi, olo, ohi);
            end
         end else begin
            p = with_axis(p, a, noise_coord(), noise_coord(), noise_coord(), noise_coord());
         end
      end
      return p;
   endfunction

   // one req beat; may idle first, then holds valid and payload until taken
   task automatic offer_pair(input box_pair_type p);
      if (idle_enable && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (idle_enable && $urandom_range(99) < 34);
      end
      req_own_min_x   <= p.own_min[0];
      req_own_min_y   <= p.own_min[1];
      req_own_min_z   <= p.own_min[2];
      req_own_max_x   <= p.own_max[0];
      req_own_max_y   <= p.own_max[1];
      req_own_max_z   <= p.own_max[2];
      req_other_min_x <= p.other_min[0];
      req_other_min_y <= p.other_min[1];
      req_other_min_z <= p.other_min[2];
      req_other_max_x <= p.other_max[0];
      req_other_max_y <= p.other_max[1];
      req_other_max_z <= p.other_max[2];
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= !(idle_enable && $urandom_range(99) < 34);
         end
      end
   end

   // beats are taken from values sampled at the edge, before any update
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         seen_pair.own_min   = {req_own_min_z, req_own_min_y, req_own_min_x};
         seen_pair.own_max   = {req_own_max_z, req_own_max_y, req_own_max_x};
         seen_pair.other_min = {req_other_min_z, req_other_min_y, req_other_min_x};
         seen_pair.other_max = {req_other_max_z, req_other_max_y, req_other_max_x};
         book.note_pair(seen_pair);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         seen_push.hit      = rsp_hit;
         seen_push.min_axis = rsp_min_axis;
         seen_push.push_x   = rsp_push_x;
         seen_push.push_y   = rsp_push_y;
         seen_push.push_z   = rsp_push_z;
         book.check_push(seen_push);
      end
   end

   // watchdog: too long with no beat on either channel means a hang
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("aabb_penetration_vector_top verification failed");
      $finish;
   end

   initial begin
      box_pair_type p;

      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // each nesting case on each axis, with the other two axes overlapping widely
      for (int a = 0; a < 3; a++) begin
         for (int c = 0; c < 4; c++) begin
            p = uniform_pair(0, 100 * ONE, -10 * ONE, 110 * ONE);
            case (c)
               0: p = with_axis(p, a, 0, 2 * ONE, -5 * ONE, 10 * ONE);      // other covers own
               1: p = with_axis(p, a, 0, 10 * ONE, 8 * ONE, 20 * ONE);      // other sticks out above
               2: p = with_axis(p, a, 0, 10 * ONE, -5 * ONE, 2 * ONE);      // other sticks out below
               default: p = with_axis(p, a, 0, 10 * ONE, 3 * ONE, 5 * ONE); // other inside own
            endcase
            offer_pair(p);
         end
      end

      // three-way tie goes to x
      offer_pair(uniform_pair(0, 10 * ONE, 3 * ONE, 5 * ONE));
      // y and z tie below x, y wins
      p = uniform_pair(0, 10 * ONE, 3 * ONE, 5 * ONE);
      offer_pair(with_axis(p, 0, 0, 10 * ONE, -ONE, 11 * ONE));
      // equal centers push positive
      offer_pair(uniform_pair(0, 10 * ONE, 2 * ONE, 8 * ONE));
      // apart on x with other above, then apart on z with other below
      p = uniform_pair(0, 100 * ONE, -10 * ONE, 110 * ONE);
      offer_pair(with_axis(p, 0, 0, 10 * ONE, 20 * ONE, 30 * ONE));
      offer_pair(with_axis(p, 2, 20 * ONE, 30 * ONE, 0, 10 * ONE));
      // boxes just touching: zero overlap, no hit
      offer_pair(uniform_pair(0, 10 * ONE, 10 * ONE, 20 * ONE));
      // own box inside out
      offer_pair(uniform_pair(10 * ONE, 0, 2 * ONE, 5 * ONE));
      // coordinate extremes, overlaps at full magnitude either sign
      offer_pair(uniform_pair(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
      offer_pair(uniform_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
      offer_pair(uniform_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      offer_pair(uniform_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
      // all zeros and all ones
      offer_pair(uniform_pair(0, 0, 0, 0));
      offer_pair(uniform_pair(-1, -1, -1, -1));

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         // long receiver hold-off while the sender keeps offering
         if (i == 400) begin
            hold_rsp = 1'b1;
         end
         // back-to-back stretch with no idling on either side
         if (i == 700) begin
            idle_enable = 1'b0;
         end
         if (i == 1000) begin
            idle_enable = 1'b1;
         end
         offer_pair(random_pair());
      end
      req_valid <= 1'b0;

      // let the monitor log the last beat, then drain and allow for latency
      @(posedge clock);
      while (book.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      if (book.mismatches == 0) begin
         $display("aabb_penetration_vector_top verification clean");
      end else begin
         $display("aabb_penetration_vector_top verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/apv_pkg.sv
rtl/core/apv_axis.sv
rtl/core/apv_select.sv
rtl/core/aabb_penetration_vector_top.sv
tb/tb_aabb_penetration_vector_top.sv
